// ===== rtl/i2cbb_pkg.sv =====
// ============================================================================
// i2cbb_pkg
// Shared types and constants for the I2C bit-bang master core.
// ============================================================================
package i2cbb_pkg;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [7:0] RST_PHASE_TICKS   = 8'd1;
    localparam logic [7:0] RST_ACK_POLL_LIM  = 8'd50;
    localparam logic [7:0] RST_READ_SETTLE   = 8'd25;

    // Bits per byte transfer
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_TICKS = 2'd0,
        CFG_ACK_POLL    = 2'd1,
        CFG_READ_SETTLE = 2'd2
    } t_cfg_idx;

    // One tick as it travels from front to back
    typedef struct packed {
        logic       cmd_valid;
        t_req       req;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    // One result of the sequencer
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] rd_data;
        logic       ack_seen;
        logic       ack_timeout;
    } t_result;

    // Configuration write transaction
    typedef struct packed {
        logic                 valid;
        t_cfg_idx             index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/i2cbb_front.sv =====
// ============================================================================
// i2cbb_front
// Input stage: accepts stream transactions, unpacks and classifies each tick.
// ============================================================================
module i2cbb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [i2cbb_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [i2cbb_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                             o_vld,
    output i2cbb_pkg::t_item                 o_item,
    input  logic                             i_ready
);

    logic             r_vld;
    i2cbb_pkg::t_item r_item;
    i2cbb_pkg::t_item n_item;
    logic             w_take;

    assign o_s_axis_tready = !r_vld || i_ready;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_item.cmd_valid = i_s_axis_tuser[0];
        n_item.req       = i2cbb_pkg::t_req'(i_s_axis_tuser[2:1]);
        n_item.wr_data   = i_s_axis_tdata[7:0];
        n_item.send_ack  = i_s_axis_tdata[8];
        n_item.sda_in    = i_s_axis_tdata[9];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== rtl/i2cbb_queue.sv =====
// ============================================================================
// i2cbb_queue
// Short FIFO of ticks between the front and the sequencer.
// ============================================================================
module i2cbb_queue #(
    parameter int DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  i2cbb_pkg::t_item                i_item,
    output logic                            o_ready,
    input  logic                            i_pop,
    output logic                            o_vld,
    output i2cbb_pkg::t_item                o_item,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    i2cbb_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_vld   = (r_count != '0);
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== rtl/i2cbb_back.sv =====
// ============================================================================
// i2cbb_back
// Phase sequencer: plays one tick per pop and registers the result.
// ============================================================================
module i2cbb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cbb_pkg::t_cfg_wr  i_cfg,
    input  logic                i_vld,
    input  i2cbb_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_vld,
    output i2cbb_pkg::t_result  o_res,
    input  logic                i_ready
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3,
        PH_WB_SET, PH_WB_HI, PH_WB_LO, PH_AK_REL, PH_AK_LO, PH_AK_HI,
        PH_AK_POLL, PH_AK_END, PH_AK_TMO, PH_RD_REL, PH_RB_LO, PH_RB_HI,
        PH_AC1, PH_AC2, PH_AC3, PH_AC4, PH_NA1, PH_NA2, PH_NA3
    } t_phase;

    function automatic logic is_final(input t_phase p);
        is_final = (p == PH_ST3) || (p == PH_SP3) || (p == PH_AK_END) ||
                   (p == PH_AK_TMO) || (p == PH_AC4) || (p == PH_NA3);
    endfunction

    // configuration
    logic [7:0] r_phase_ticks;
    logic [7:0] r_ack_poll_lim;
    logic [7:0] r_read_settle;

    // sequencer state; pins are {drive, sda, scl}
    t_phase     r_phase,     n_phase;
    logic [3:0] r_bit_cnt,   n_bit_cnt;
    logic [7:0] r_shift,     n_shift;
    logic [7:0] r_tick,      n_tick;
    logic [7:0] r_poll,      n_poll;
    logic       r_ack_choice, n_ack_choice;
    logic [2:0] r_pins,      n_pins;
    logic [1:0] r_ack_status, n_ack_status;
    logic [7:0] r_rd_hold,   n_rd_hold;

    logic                 r_out_vld;
    i2cbb_pkg::t_result   r_res,  n_res;

    always_comb begin
        logic       v_enter;
        t_phase     v_target;
        logic [7:0] v_unit;
        logic [7:0] v_lim;
        logic [7:0] v_dur;
        logic [7:0] v_poll;
        logic       v_busy;
        logic       v_done;

        n_phase      = r_phase;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_tick       = r_tick;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_pins       = r_pins;
        n_ack_status = r_ack_status;
        n_rd_hold    = r_rd_hold;
        v_enter      = 1'b0;
        v_target     = PH_IDLE;
        v_unit       = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
        v_lim        = (r_ack_poll_lim == 8'd0) ? 8'd1 : r_ack_poll_lim;
        v_dur        = v_unit;
        v_poll       = r_poll + 8'd1;

        // pick the phase to enter this tick
        if (r_phase == PH_IDLE) begin
            if (i_item.cmd_valid) begin
                v_enter = 1'b1;
                case (i_item.req)
                    i2cbb_pkg::REQ_START: v_target = PH_ST1;
                    i2cbb_pkg::REQ_STOP:  v_target = PH_SP1;
                    i2cbb_pkg::REQ_WRITE: begin
                        n_shift      = i_item.wr_data;
                        n_bit_cnt    = 4'd0;
                        n_poll       = 8'd0;
                        n_ack_status = 2'd0;
                        v_target     = PH_WB_SET;
                    end
                    i2cbb_pkg::REQ_READ: begin
                        n_shift      = 8'd0;
                        n_bit_cnt    = 4'd0;
                        n_ack_choice = i_item.send_ack;
                        v_target     = PH_RD_REL;
                    end
                    default: v_target = PH_IDLE;
                endcase
            end
        end else if (r_tick != 8'd0) begin
            n_tick = r_tick - 8'd1;
        end else begin
            v_enter = 1'b1;
            case (r_phase)
                PH_ST1:    v_target = PH_ST2;
                PH_ST2:    v_target = PH_ST3;
                PH_SP1:    v_target = PH_SP2;
                PH_SP2:    v_target = PH_SP3;
                PH_WB_SET: v_target = PH_WB_HI;
                PH_WB_HI:  v_target = PH_WB_LO;
                PH_WB_LO: begin
                    n_shift   = {r_shift[6:0], 1'b0};
                    n_bit_cnt = r_bit_cnt + 4'd1;
                    v_target  = (n_bit_cnt < i2cbb_pkg::BITS_PER_BYTE) ?
                                PH_WB_SET : PH_AK_REL;
                end
                PH_AK_REL:  v_target = PH_AK_LO;
                PH_AK_LO:   v_target = PH_AK_HI;
                PH_AK_HI:   v_target = PH_AK_POLL;
                PH_AK_POLL: v_target = PH_AK_POLL;
                PH_RD_REL:  v_target = PH_RB_LO;
                PH_RB_LO:   v_target = PH_RB_HI;
                PH_RB_HI: begin
                    n_bit_cnt = r_bit_cnt + 4'd1;
                    if (n_bit_cnt < i2cbb_pkg::BITS_PER_BYTE) begin
                        v_target = PH_RB_LO;
                    end else begin
                        n_rd_hold = r_shift;
                        v_target  = r_ack_choice ? PH_AC1 : PH_NA1;
                    end
                end
                PH_AC1: v_target = PH_AC2;
                PH_AC2: v_target = PH_AC3;
                PH_AC3: v_target = PH_AC4;
                PH_NA1: v_target = PH_NA2;
                PH_NA2: v_target = PH_NA3;
                default: begin
                    v_enter = 1'b0;
                    n_phase = PH_IDLE;
                    n_tick  = 8'd0;
                end
            endcase
        end

        // enter the phase: set pins and its length
        if (v_enter) begin
            n_phase = v_target;
            case (v_target)
                PH_ST1:    n_pins = 3'b111;
                PH_ST2:    n_pins = 3'b101;
                PH_ST3:    n_pins = 3'b100;
                PH_SP1:    n_pins = 3'b100;
                PH_SP2:    n_pins = 3'b101;
                PH_SP3:    n_pins = 3'b111;
                PH_WB_SET: n_pins = {1'b1, n_shift[7], 1'b0};
                PH_WB_HI:  n_pins[0] = 1'b1;
                PH_WB_LO:  n_pins[0] = 1'b0;
                PH_AK_REL: n_pins = 3'b010;
                PH_AK_LO:  n_pins[0] = 1'b0;
                PH_AK_HI:  n_pins[0] = 1'b1;
                PH_AK_POLL: begin
                    if (!i_item.sda_in) begin
                        n_pins[0]    = 1'b0;
                        n_ack_status = 2'd1;
                        n_phase      = PH_AK_END;
                    end else begin
                        n_poll = v_poll;
                        if (v_poll >= v_lim) begin
                            n_pins[0]    = 1'b0;
                            n_ack_status = 2'd2;
                            n_phase      = PH_AK_TMO;
                            v_dur        = 8'd1;
                        end else begin
                            n_pins[0] = 1'b1;
                        end
                    end
                end
                PH_RD_REL: begin
                    // zero settle skips straight to the first bit low phase
                    if (r_read_settle == 8'd0) begin
                        n_pins  = 3'b010;
                        n_phase = PH_RB_LO;
                    end else begin
                        n_pins = {1'b0, 1'b1, n_pins[0]};
                        v_dur  = r_read_settle;
                    end
                end
                PH_RB_LO:  n_pins[0] = 1'b0;
                PH_RB_HI: begin
                    n_pins[0] = 1'b1;
                    n_shift   = {n_shift[6:0], i_item.sda_in};
                end
                PH_AC1:    n_pins[0] = 1'b0;
                PH_AC2:    n_pins = 3'b100;
                PH_AC3:    n_pins[0] = 1'b1;
                PH_AC4:    n_pins[0] = 1'b0;
                PH_NA1:    n_pins = 3'b110;
                PH_NA2:    n_pins[0] = 1'b1;
                PH_NA3:    n_pins[0] = 1'b0;
                default: begin
                    n_phase = PH_IDLE;
                    v_dur   = 8'd1;
                end
            endcase
            n_tick = v_dur - 8'd1;
        end

        v_busy = (n_phase != PH_IDLE);
        v_done = v_busy && (n_tick == 8'd0) && is_final(n_phase);
        if (v_done) begin
            n_phase = PH_IDLE;
        end

        n_res.scl         = n_pins[0];
        n_res.sda_out     = n_pins[2] ? n_pins[1] : 1'b1;
        n_res.sda_drive   = n_pins[2];
        n_res.busy        = v_busy;
        n_res.done        = v_done;
        n_res.rd_data     = n_rd_hold;
        n_res.ack_seen    = n_ack_status[0];
        n_res.ack_timeout = n_ack_status[1];
    end

    assign o_pop = i_vld && (!r_out_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks  <= i2cbb_pkg::RST_PHASE_TICKS;
            r_ack_poll_lim <= i2cbb_pkg::RST_ACK_POLL_LIM;
            r_read_settle  <= i2cbb_pkg::RST_READ_SETTLE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                i2cbb_pkg::CFG_PHASE_TICKS: r_phase_ticks  <= i_cfg.data;
                i2cbb_pkg::CFG_ACK_POLL:    r_ack_poll_lim <= i_cfg.data;
                i2cbb_pkg::CFG_READ_SETTLE: r_read_settle  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'd0;
            r_tick       <= 8'd0;
            r_poll       <= 8'd0;
            r_ack_choice <= 1'b0;
            r_pins       <= 3'b111;
            r_ack_status <= 2'd0;
            r_rd_hold    <= 8'd0;
            r_out_vld    <= 1'b0;
            r_res        <= '0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_bit_cnt    <= n_bit_cnt;
                r_shift      <= n_shift;
                r_tick       <= n_tick;
                r_poll       <= n_poll;
                r_ack_choice <= n_ack_choice;
                r_pins       <= n_pins;
                r_ack_status <= n_ack_status;
                r_rd_hold    <= n_rd_hold;
                r_out_vld    <= 1'b1;
                r_res        <= n_res;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_res;

endmodule

// ===== rtl/i2c_bit_bang_master_core.sv =====
// ============================================================================
// i2c_bit_bang_master_core
// I2C bit-bang master: one stream transaction per delay tick in, one pin and
// status result per tick out.
// ============================================================================
// Each input transaction is one delay tick: it carries the sampled SDA level
// and optionally a command (start, stop, write byte, read byte) that is taken
// only while the sequencer is idle. Each tick yields exactly one result with
// the SCL/SDA levels to drive, busy, done (on tlast), the last read byte and
// the last write's acknowledge outcome. The core takes one tick per clock and
// returns one result per clock while the master side is ready; a held result
// stalls the sequencer and, through the queue, the input. Each tick moves
// through the input register, the tick queue and the result register. The
// phase sequencer updates its state once per tick, which sets that rate. Bus
// timing is counted in ticks, so phase length, acknowledge poll limit and
// read settle time are set through the configuration channel; write those
// only while no tick is in flight.
// ============================================================================
module i2c_bit_bang_master_core #(
    parameter int QUEUE_DEPTH = i2cbb_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: [7:0] wr_data, [8] send_ack, [9] sda_in, [15:10] zero
    input  logic [i2cbb_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: [0] cmd_valid, [2:1] req_type
    input  logic [i2cbb_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // master side
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res,
    //        [11:4] rd_data, [12] ack_seen, [13] ack_timeout, [15:14] zero
    output logic [i2cbb_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // tlast: done_res
    output logic                             o_m_axis_tlast,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [i2cbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [i2cbb_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                 w_front_vld;
    i2cbb_pkg::t_item     w_front_item;
    logic                 w_q_ready;
    logic                 w_q_vld;
    i2cbb_pkg::t_item     w_q_item;
    logic [CW-1:0]        w_q_count;
    logic                 w_q_pop;
    logic                 w_out_vld;
    i2cbb_pkg::t_result   w_res;
    i2cbb_pkg::t_cfg_wr   w_cfg;

    // Configuration writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i2cbb_pkg::t_cfg_idx'(i_cfg_index);
    assign w_cfg.data  = i_cfg_data;

    // Front: register and decode each tick
    i2cbb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_vld           (w_front_vld),
        .o_item          (w_front_item),
        .i_ready         (w_q_ready)
    );

    // Queue: decouple front stalls from the sequencer
    i2cbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_vld),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_vld   (w_q_vld),
        .o_item  (w_q_item),
        .o_count (w_q_count)
    );

    // Back: advance the phase sequencer one tick per pop
    i2cbb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (w_q_vld),
        .i_item  (w_q_item),
        .o_pop   (w_q_pop),
        .o_vld   (w_out_vld),
        .o_res   (w_res),
        .i_ready (i_m_axis_tready)
    );

    // Pack the result transaction
    assign o_m_axis_tvalid = w_out_vld;
    assign o_m_axis_tlast  = w_res.done;
    assign o_m_axis_tdata  = {2'b00, w_res.ack_timeout, w_res.ack_seen,
                              w_res.rd_data, w_res.busy, w_res.sda_drive,
                              w_res.sda_out, w_res.scl};

    // A held result must block the sequencer
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_vld && !i_m_axis_tready) |-> !w_q_pop)
        else $error("sequencer advanced while result was stalled");

    // Queue never exceeds its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= CW'(QUEUE_DEPTH))
        else $error("tick queue overflow");

    // A finishing tick is always a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_vld && w_res.done) |-> w_res.busy)
        else $error("done reported on an idle tick");

    // Released SDA reads high
    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_vld && !w_res.sda_drive) |-> w_res.sda_out)
        else $error("released SDA reported low");

endmodule
